// File: src/edcr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edcr_pkg: shared types and constants for the debug command responder
// Holds the beat structs, result codes and the job record that the front end
// hands to the back end.
// ----------------------------------------------------------------------------
package edcr_pkg;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  frame_byte;
    logic        end_of_frame;
    logic [15:0] read_data;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [5:0]  tx_offset;
    logic [7:0]  tx_byte;
    logic [15:0] debug_addr;
    logic [15:0] debug_data;
    logic        last;
  } out_beat_t;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_BYTE   = 2'd2;
  localparam logic [1:0] KIND_COMMIT = 2'd3;

  localparam logic [7:0] SUB_WRITE       = 8'h06;
  localparam logic [7:0] SUB_READ        = 8'h07;
  localparam logic [7:0] SUB_WRITE_REPLY = 8'h08;
  localparam logic [7:0] BCAST_BYTE      = 8'hff;
  localparam logic [7:0] HDR_LEN_BYTE    = 8'd60;
  localparam logic [7:0] REPLY_LEN       = 8'd4;
  localparam logic [5:0] MIN_LAST_POS    = 6'd27;

  localparam logic [2:0] REG_MAC_A     = 3'd0;
  localparam logic [2:0] REG_MAC_B     = 3'd1;
  localparam logic [2:0] REG_MATCH_ET  = 3'd2;
  localparam logic [2:0] REG_REPLY_ET  = 3'd3;
  localparam logic [2:0] REG_REQ_CLASS = 3'd4;
  localparam logic [2:0] REG_REP_CLASS = 3'd5;

  typedef enum logic [1:0] {
    VERDICT_NONE  = 2'd0,
    VERDICT_A     = 2'd1,
    VERDICT_B     = 2'd2,
    VERDICT_BCAST = 2'd3
  } verdict_t;

  // One unit of work for the back end.
  typedef struct packed {
    logic        do_write;
    logic        do_read;
    logic        do_reply;
    logic [47:0] src_mac;
    logic [7:0]  subtype;
    logic [15:0] seq;
    logic [15:0] addr;
    logic [15:0] data;
  } job_t;

  typedef enum logic [1:0] {
    BE_IDLE  = 2'd0,
    BE_CMD   = 2'd1,
    BE_REPLY = 2'd2
  } be_state_t;

endpackage

// File: src/eth_debug_command_responder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// eth_debug_command_responder: Ethernet debug command responder
// Parses received frames, runs debug writes and reads, and writes reply
// frames into the transmit buffer as offset/byte beats.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake          Payload
// in_*      input      in_valid/in_stall  edcr_pkg::in_beat_t
// out_*     output     out_valid/out_stall edcr_pkg::out_beat_t
// cfg_*     input      cfg_we             cfg_index, cfg_data
//
// The parser takes one input beat every cycle while the job queue has room.
// A command is one output beat; a reply is min(TX_INFO_BYTES, 8) header beats,
// 24 field byte beats and a commit beat, one beat a cycle through the executor
// unless out_stall holds it. Each job passes the executor's idle state before
// its first beat. The four-deep job queue absorbs out_stall before in_stall
// rises. Synchronous reset clears control and parser state, sets cfg defaults.
// ----------------------------------------------------------------------------
module eth_debug_command_responder #(
  parameter int TX_INFO_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  edcr_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output edcr_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [47:0]         cfg_data
);
  import edcr_pkg::*;

  logic [47:0] mac_a_r, mac_b_r;
  logic [15:0] match_et_r, reply_et_r;
  logic [7:0]  req_class_r, rep_class_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mac_a_r <= '0; mac_b_r <= '0;
      match_et_r <= 16'd2063; reply_et_r <= 16'd2063;
      req_class_r <= 8'd4; rep_class_r <= 8'd132;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAC_A:     mac_a_r <= cfg_data;
        REG_MAC_B:     mac_b_r <= cfg_data;
        REG_MATCH_ET:  match_et_r <= cfg_data[15:0];
        REG_REPLY_ET:  reply_et_r <= cfg_data[15:0];
        REG_REQ_CLASS: req_class_r <= cfg_data[7:0];
        REG_REP_CLASS: rep_class_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic q_wr, q_full, q_valid, q_take;
  job_t q_in, q_out;

  edcr_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data,
    .mac_a(mac_a_r), .mac_b(mac_b_r), .match_et(match_et_r),
    .req_class(req_class_r),
    .job_valid(q_wr), .job(q_in), .job_full(q_full)
  );

  edcr_queue #(.DEPTH_LOG2(2)) u_queue (
    .clk, .rst_n, .wr_en(q_wr), .wr_job(q_in), .full(q_full),
    .rd_valid(q_valid), .rd_job(q_out), .rd_en(q_take)
  );

  edcr_back #(.TX_INFO_BYTES(TX_INFO_BYTES)) u_back (
    .clk, .rst_n, .job_valid(q_valid), .job(q_out), .job_take(q_take),
    .mac_a(mac_a_r), .reply_et(reply_et_r), .rep_class(rep_class_r),
    .out_valid, .out_stall, .out_data
  );

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output changed");
  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_COMMIT) |-> out_data.last)
    else $error("commit without last");
  a_read_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.kind == KIND_READ) |-> out_data.last)
    else $error("read request not last");

endmodule

// File: src/edcr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edcr_front: frame parser
// Walks the received bytes, decides the address verdict, captures the fields
// and emits one job per command or read return.
// ----------------------------------------------------------------------------
module edcr_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  edcr_pkg::in_beat_t in_data,
  input  logic [47:0]        mac_a,
  input  logic [47:0]        mac_b,
  input  logic [15:0]        match_et,
  input  logic [7:0]         req_class,
  output logic               job_valid,
  output edcr_pkg::job_t     job,
  input  logic               job_full
);
  import edcr_pkg::*;

  logic [5:0]  pos_r;
  verdict_t    verdict_r;
  logic [47:0] src_r;
  logic [15:0] ftype_r, mtype_r, seq_r, addr_r, data_r;
  logic        await_r;

  logic [5:0]  pos_nxt;
  verdict_t    verdict_nxt;
  logic [47:0] src_nxt;
  logic [15:0] ftype_nxt, mtype_nxt, seq_nxt, addr_nxt, data_nxt;
  logic        await_nxt;
  logic        acc;
  logic [7:0]  b, want;
  logic [2:0]  bi;

  assign in_stall = job_full;
  assign acc = in_valid && !job_full;
  assign b = in_data.frame_byte;
  assign bi = 3'(pos_r);

  always_comb begin
    case (verdict_r)
      VERDICT_A: want = mac_a[8*(5-bi) +: 8];
      VERDICT_B: want = mac_b[8*(5-bi) +: 8];
      default:   want = BCAST_BYTE;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r; verdict_nxt = verdict_r; src_nxt = src_r;
    ftype_nxt = ftype_r; mtype_nxt = mtype_r; seq_nxt = seq_r;
    addr_nxt = addr_r; data_nxt = data_r; await_nxt = await_r;
    job_valid = 1'b0;
    job = '0;
    if (acc) begin
      if (in_data.opcode) begin
        if (await_r) begin
          await_nxt = 1'b0;
          job_valid = 1'b1;
          job.do_reply = 1'b1;
          job.src_mac = src_r; job.subtype = mtype_r[7:0]; job.seq = seq_r;
          job.addr = addr_r; job.data = in_data.read_data;
        end
      end else if (!await_r) begin
        if (pos_r == 6'd0) begin
          if (b == mac_a[47:40]) verdict_nxt = VERDICT_A;
          else if (b == mac_b[47:40]) verdict_nxt = VERDICT_B;
          else if (b == BCAST_BYTE) verdict_nxt = VERDICT_BCAST;
          else verdict_nxt = VERDICT_NONE;
        end else if (pos_r < 6'd6) begin
          if (b != want) verdict_nxt = VERDICT_NONE;
        end else if (pos_r < 6'd12) src_nxt = {src_r[39:0], b};
        else if (pos_r < 6'd14) ftype_nxt = {ftype_r[7:0], b};
        else if (pos_r == 6'd18) mtype_nxt[7:0] = b;
        else if (pos_r == 6'd19) mtype_nxt[15:8] = b;
        else if (pos_r == 6'd20) seq_nxt[7:0] = b;
        else if (pos_r == 6'd21) seq_nxt[15:8] = b;
        else if (pos_r == 6'd24) addr_nxt[7:0] = b;
        else if (pos_r == 6'd25) addr_nxt[15:8] = b;
        else if (pos_r == 6'd26) data_nxt[7:0] = b;
        else if (pos_r == 6'd27) data_nxt[15:8] = b;
        pos_nxt = (pos_r == 6'd63) ? pos_r : pos_r + 6'd1;
        if (in_data.end_of_frame) begin
          // The checks see the updated fields, as the last byte may be one.
          if (pos_r >= MIN_LAST_POS && verdict_nxt != VERDICT_NONE
              && ftype_nxt == match_et && mtype_nxt[15:8] == req_class) begin
            job.src_mac = src_nxt; job.subtype = mtype_nxt[7:0];
            job.seq = seq_nxt; job.addr = addr_nxt; job.data = data_nxt;
            if (mtype_nxt[7:0] == SUB_WRITE) begin
              job_valid = 1'b1; job.do_write = 1'b1;
            end else if (mtype_nxt[7:0] == SUB_WRITE_REPLY) begin
              job_valid = 1'b1; job.do_write = 1'b1; job.do_reply = 1'b1;
            end else if (mtype_nxt[7:0] == SUB_READ) begin
              job_valid = 1'b1; job.do_read = 1'b1; await_nxt = 1'b1;
            end
          end
          pos_nxt = '0;
          verdict_nxt = VERDICT_NONE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; verdict_r <= VERDICT_NONE; src_r <= '0; ftype_r <= '0;
      mtype_r <= '0; seq_r <= '0; addr_r <= '0; data_r <= '0; await_r <= 1'b0;
    end else begin
      pos_r <= pos_nxt; verdict_r <= verdict_nxt; src_r <= src_nxt;
      ftype_r <= ftype_nxt; mtype_r <= mtype_nxt; seq_r <= seq_nxt;
      addr_r <= addr_nxt; data_r <= data_nxt; await_r <= await_nxt;
    end
  end

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    job_full |-> in_stall) else $error("front accepted while queue full");
  a_read_arms: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job.do_read) |=> await_r) else $error("read not armed");
  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> !(job.do_read && job.do_write)) else $error("bad job");

endmodule

// File: src/edcr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edcr_queue: job queue
// Small FIFO that lets the parser run on while the back end stalls.
// ----------------------------------------------------------------------------
module edcr_queue #(
  parameter int DEPTH_LOG2 = 2
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_en,
  input  edcr_pkg::job_t wr_job,
  output logic           full,
  output logic           rd_valid,
  output edcr_pkg::job_t rd_job,
  input  logic           rd_en
);
  import edcr_pkg::*;

  localparam int DEPTH = 1 << DEPTH_LOG2;

  job_t mem_r [DEPTH];
  logic [DEPTH_LOG2:0] wp_r, rp_r;
  logic [DEPTH_LOG2:0] count;

  assign count = wp_r - rp_r;
  assign full = count == (DEPTH_LOG2+1)'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_job = mem_r[rp_r[DEPTH_LOG2-1:0]];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r[DEPTH_LOG2-1:0]] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en && rd_valid) rp_r <= rp_r + 1'b1;
    end
  end

  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !wr_en) else $error("queue overflow");
  a_no_under: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> rd_valid) else $error("queue underflow");
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    count <= (DEPTH_LOG2+1)'(DEPTH)) else $error("queue count");

endmodule

// File: src/edcr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edcr_back: command executor
// Emits a job's debug write or read request, if any; for a reply job it then
// steps through the reply bytes one beat a cycle while unstalled, then commits.
// ----------------------------------------------------------------------------
module edcr_back #(
  parameter int TX_INFO_BYTES = 8
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  edcr_pkg::job_t      job,
  output logic                job_take,
  input  logic [47:0]         mac_a,
  input  logic [15:0]         reply_et,
  input  logic [7:0]          rep_class,
  output logic                out_valid,
  input  logic                out_stall,
  output edcr_pkg::out_beat_t out_data
);
  import edcr_pkg::*;

  localparam int HDR = (TX_INFO_BYTES < 8) ? TX_INFO_BYTES : 8;
  localparam int NREP = HDR + 25;
  localparam int IW = 6;

  be_state_t   state_r, state_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic        fire;
  logic [5:0]  off;
  logic [7:0]  byt;
  int          k;

  assign fire = out_valid && !out_stall;

  // Reply entry idx_r: header, then 24 fixed entries, then the commit.
  always_comb begin
    k = int'(idx_r) - HDR;
    off = '0; byt = '0;
    if (int'(idx_r) < HDR) begin
      off = 6'(idx_r);
      byt = (idx_r < IW'(2)) ? HDR_LEN_BYTE : 8'd0;
    end else begin
      case (k)
        0, 1, 2, 3, 4, 5: begin
          off = 6'(TX_INFO_BYTES + k); byt = job.src_mac[8*(5-k) +: 8];
        end
        6, 7, 8, 9, 10, 11: begin
          off = 6'(TX_INFO_BYTES + k); byt = mac_a[8*(11-k) +: 8];
        end
        12: begin off = 6'(TX_INFO_BYTES + 12); byt = reply_et[15:8]; end
        13: begin off = 6'(TX_INFO_BYTES + 13); byt = reply_et[7:0]; end
        14: begin off = 6'(TX_INFO_BYTES + 18); byt = job.subtype; end
        15: begin off = 6'(TX_INFO_BYTES + 19); byt = rep_class; end
        16: begin off = 6'(TX_INFO_BYTES + 20); byt = job.seq[7:0]; end
        17: begin off = 6'(TX_INFO_BYTES + 21); byt = job.seq[15:8]; end
        18: begin off = 6'(TX_INFO_BYTES + 22); byt = REPLY_LEN; end
        19: begin off = 6'(TX_INFO_BYTES + 23); byt = 8'd0; end
        20: begin off = 6'(TX_INFO_BYTES + 24); byt = job.addr[7:0]; end
        21: begin off = 6'(TX_INFO_BYTES + 25); byt = job.addr[15:8]; end
        22: begin off = 6'(TX_INFO_BYTES + 26); byt = job.data[7:0]; end
        23: begin off = 6'(TX_INFO_BYTES + 27); byt = job.data[15:8]; end
        default: begin off = '0; byt = '0; end
      endcase
    end
  end

  always_comb begin
    state_nxt = state_r; idx_nxt = idx_r;
    out_valid = 1'b0; out_data = '0; job_take = 1'b0;
    case (state_r)
      BE_IDLE: begin
        if (job_valid) begin
          idx_nxt = '0;
          state_nxt = (job.do_write || job.do_read) ? BE_CMD : BE_REPLY;
        end
      end
      BE_CMD: begin
        out_valid = 1'b1;
        out_data.kind = job.do_read ? KIND_READ : KIND_WRITE;
        out_data.debug_addr = job.addr;
        out_data.debug_data = job.do_read ? 16'd0 : job.data;
        out_data.last = !job.do_reply;
        if (fire) begin
          if (job.do_reply) state_nxt = BE_REPLY;
          else begin state_nxt = BE_IDLE; job_take = 1'b1; end
        end
      end
      BE_REPLY: begin
        out_valid = 1'b1;
        if (int'(idx_r) == NREP - 1) begin
          out_data.kind = KIND_COMMIT;
          out_data.last = 1'b1;
        end else begin
          out_data.kind = KIND_BYTE;
          out_data.tx_offset = off;
          out_data.tx_byte = byt;
        end
        if (fire) begin
          if (int'(idx_r) == NREP - 1) begin
            state_nxt = BE_IDLE; job_take = 1'b1;
          end else idx_nxt = idx_r + 1'b1;
        end
      end
      default: state_nxt = BE_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE; idx_r <= '0;
    end else begin
      state_r <= state_nxt; idx_r <= idx_nxt;
    end
  end

  a_take_done: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> (fire && out_data.last)) else $error("job retired early");
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    int'(idx_r) < NREP) else $error("reply index overrun");
  a_busy_job: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != BE_IDLE |-> job_valid) else $error("executing without job");

endmodule
